@@ rtl/core/lzwd_pkg.sv @@
// shared types and constants of the lz word history decompressor
`timescale 1ns / 1ps

package lzwd_pkg;

  localparam int WORD_W           = 16;
  localparam int TOKENS_PER_GROUP = 32;
  localparam int TOK_W            = $clog2(TOKENS_PER_GROUP);
  localparam int POS_W            = 6;
  localparam int LEN_W            = 5;
  localparam int DIST_SHIFT       = 5;
  localparam int DIST_W           = WORD_W - DIST_SHIFT;
  localparam int CNT_W            = 6;
  localparam int CMDQ_DEPTH       = 4;
  localparam int CMDQ_AW          = $clog2(CMDQ_DEPTH);

  // group position codes
  localparam logic [POS_W-1:0] POS_FLAG_LO     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FLAG_HI     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST_TOKEN = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST_TOKEN  = POS_W'(TOKENS_PER_GROUP + 1);

  // copy length bias: the low field holds length minus two
  localparam logic [CNT_W-1:0] LEN_BIAS = CNT_W'(2);

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [WORD_W-1:0] word;
    logic              eos;
  } cmd_t;

endpackage

@@ rtl/core/lzwd_stream_if.sv @@
// stream interfaces for compressed input words and decompressed output words
`timescale 1ns / 1ps

interface lzwd_in_if
  import lzwd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              end_of_stream;

  modport source (output valid, output data_word, output end_of_stream, input ready);
  modport sink   (input valid, input data_word, input end_of_stream, output ready);
endinterface

interface lzwd_out_if
  import lzwd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic              last_of_run;

  modport source (output valid, output out_word, output last_of_run, input ready);
  modport sink   (input valid, input out_word, input last_of_run, output ready);
endinterface

@@ rtl/core/lzwd_front.sv @@
// front end: tracks group position and flag mask, classifies tokens into commands
`timescale 1ns / 1ps

module lzwd_front
  import lzwd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lzwd_in_if.sink   cmp_words,
  output logic      push_valid,
  output cmd_t      push_cmd,
  input  logic      push_ready
);

  logic [POS_W-1:0]            pos;
  logic [TOKENS_PER_GROUP-1:0] mask;
  logic [TOK_W-1:0]            tok_idx;
  logic                        is_flag;
  logic                        fire;

  assign tok_idx         = TOK_W'(pos - POS_FIRST_TOKEN);
  assign is_flag         = (pos == POS_FLAG_LO) || (pos == POS_FLAG_HI);
  assign cmp_words.ready = push_ready;
  assign fire            = cmp_words.valid && cmp_words.ready;

  always_comb begin
    push_cmd.word = cmp_words.data_word;
    push_cmd.eos  = cmp_words.end_of_stream;
    if (is_flag) begin
      push_cmd.kind = CMD_NONE;
    end else if (mask[tok_idx]) begin
      push_cmd.kind = CMD_LIT;
    end else begin
      push_cmd.kind = CMD_COPY;
    end
    // flag halves only travel on when they end a stream
    push_valid = fire && (!is_flag || cmp_words.end_of_stream);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= POS_FLAG_LO;
      mask <= '0;
    end else if (fire) begin
      if (cmp_words.end_of_stream) begin
        pos  <= POS_FLAG_LO;
        mask <= '0;
      end else begin
        priority if (pos == POS_FLAG_LO) begin
          mask[WORD_W-1:0] <= cmp_words.data_word;
          pos              <= POS_FLAG_HI;
        end else if (pos == POS_FLAG_HI) begin
          mask[TOKENS_PER_GROUP-1:WORD_W] <= cmp_words.data_word;
          pos                             <= POS_FIRST_TOKEN;
        end else if (pos >= POS_LAST_TOKEN) begin
          pos <= POS_FLAG_LO;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

endmodule

@@ rtl/core/lzwd_cmd_fifo.sv @@
// small command queue between front end and back end
`timescale 1ns / 1ps

module lzwd_cmd_fifo
  import lzwd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW:0]   wr_ptr;
  logic [CMDQ_AW:0]   rd_ptr;

  assign pop_valid  = (wr_ptr != rd_ptr);
  assign push_ready = (wr_ptr != {~rd_ptr[CMDQ_AW], rd_ptr[CMDQ_AW-1:0]});
  assign pop_cmd    = q[rd_ptr[CMDQ_AW-1:0]];

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      q[wr_ptr[CMDQ_AW-1:0]] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_valid && push_ready) begin
        wr_ptr <= wr_ptr + (CMDQ_AW+1)'(1);
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + (CMDQ_AW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/lzwd_back.sv @@
// back end: history memory, copy sequencer, read stage and output register
`timescale 1ns / 1ps

module lzwd_back
  import lzwd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2048
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  lzwd_out_if.source raw_words
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [WORD_W-1:0] mem [HISTORY_DEPTH];

  // issue side
  logic [AW-1:0]     ip;
  logic              wrapped;
  logic              copy_active;
  logic [CNT_W-1:0]  copy_left;
  logic [DIST_W-1:0] copy_dist;
  logic              copy_eos;

  // read stage
  logic              r_valid;
  logic [AW-1:0]     r_addr;
  logic              r_use_hold;
  logic [WORD_W-1:0] r_hold;
  logic              r_last;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] r_word;
  logic              r_move;

  // output register
  logic              o_valid;
  logic [WORD_W-1:0] o_word;
  logic              o_last;

  logic              can_issue;
  logic              step_valid;
  logic              issue_fire;
  logic              step_is_lit;
  logic              step_last;
  logic              step_eos;
  logic [DIST_W-1:0] step_dist;
  logic [AW:0]       ip_ext;
  logic [AW:0]       dist_ext;
  logic [AW:0]       diff;
  logic [AW-1:0]     src;
  logic              src_filled;
  logic              bypass;
  logic [AW-1:0]     ip_inc;

  assign r_word    = r_use_hold ? r_hold : rd_data;
  assign r_move    = r_valid && (!o_valid || raw_words.ready);
  assign can_issue = !r_valid || r_move;

  always_comb begin
    step_valid  = copy_active || (cmd_valid && (cmd.kind != CMD_NONE));
    step_is_lit = !copy_active && (cmd.kind == CMD_LIT);
    step_dist   = copy_active ? copy_dist : cmd.word[WORD_W-1:DIST_SHIFT];
    step_last   = copy_active ? (copy_left == CNT_W'(1)) : (cmd.kind == CMD_LIT);
    step_eos    = step_last && (copy_active ? copy_eos : cmd.eos);
    issue_fire  = step_valid && can_issue;
    cmd_pop     = !copy_active && cmd_valid && ((cmd.kind == CMD_NONE) || can_issue);

    ip_ext   = {1'b0, ip};
    dist_ext = (AW+1)'(step_dist);
    diff     = ip_ext - dist_ext;
    if (ip_ext >= dist_ext) begin
      src = diff[AW-1:0];
    end else begin
      src = AW'(diff + (AW+1)'(HISTORY_DEPTH));
    end
    // slots not yet written in this stream read as zero
    src_filled = wrapped || (src < ip);
    bypass     = r_valid && (src == r_addr);
    ip_inc     = (ip == AW'(HISTORY_DEPTH - 1)) ? '0 : ip + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (issue_fire) begin
      rd_data <= mem[src];
    end
    if (r_move) begin
      mem[r_addr] <= r_word;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_fire) begin
      r_addr <= ip;
      r_last <= step_last;
      priority if (step_is_lit) begin
        r_use_hold <= 1'b1;
        r_hold     <= cmd.word;
      end else if (!src_filled) begin
        r_use_hold <= 1'b1;
        r_hold     <= '0;
      end else if (bypass) begin
        r_use_hold <= 1'b1;
        r_hold     <= r_word;
      end else begin
        r_use_hold <= 1'b0;
        r_hold     <= r_word;
      end
    end
    if (r_move) begin
      o_word <= r_word;
      o_last <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip          <= '0;
      wrapped     <= 1'b0;
      copy_active <= 1'b0;
      copy_left   <= '0;
      copy_dist   <= '0;
      copy_eos    <= 1'b0;
      r_valid     <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      if (issue_fire) begin
        if (step_eos) begin
          ip      <= '0;
          wrapped <= 1'b0;
        end else begin
          ip <= ip_inc;
          if (ip == AW'(HISTORY_DEPTH - 1)) begin
            wrapped <= 1'b1;
          end
        end
        if (!copy_active && (cmd.kind == CMD_COPY)) begin
          copy_active <= 1'b1;
          copy_left   <= CNT_W'(cmd.word[LEN_W-1:0]) + LEN_BIAS - CNT_W'(1);
          copy_dist   <= cmd.word[WORD_W-1:DIST_SHIFT];
          copy_eos    <= cmd.eos;
        end else if (copy_active) begin
          if (copy_left == CNT_W'(1)) begin
            copy_active <= 1'b0;
          end
          copy_left <= copy_left - CNT_W'(1);
        end
      end else if (cmd_pop && cmd.eos) begin
        // stream ended on a flag half
        ip      <= '0;
        wrapped <= 1'b0;
      end

      if (issue_fire) begin
        r_valid <= 1'b1;
      end else if (r_move) begin
        r_valid <= 1'b0;
      end

      if (r_move) begin
        o_valid <= 1'b1;
      end else if (raw_words.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign raw_words.valid       = o_valid;
  assign raw_words.out_word    = o_word;
  assign raw_words.last_of_run = o_last;

`ifndef SYNTHESIS
  a_copy_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    copy_active |-> (copy_left != '0))
    else $error("copy active with no words left");

  a_no_pop_mid_copy: assert property (@(posedge clk) disable iff (rst)
    copy_active |-> !cmd_pop)
    else $error("command popped during a copy");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_move) |=> (r_valid && $stable(r_addr) && $stable(r_word)))
    else $error("stalled read stage lost its word");

  a_eos_clears_pointer: assert property (@(posedge clk) disable iff (rst)
    (issue_fire && step_eos) |=> ((ip == '0) && !wrapped))
    else $error("history pointer not cleared at end of stream");
`endif

endmodule

@@ rtl/core/lz_word_history_decompressor_top.sv @@
// top level of the lz word history decompressor
`timescale 1ns / 1ps

// lz word history decompressor (lzss over 16-bit words)
// cmp_words: compressed words in, one request per word, with end_of_stream
//   on the last word of a stream. words come in groups of 34: two flag
//   halves (low then high) and 32 tokens, a set flag bit marks a literal
// raw_words: decompressed words out, last_of_run marks the final word that
//   one compressed word produced
// throughput: flag halves yield no output word and a literal yields one;
//   a copy token yields (low 5 bits + 2) words, one history read per cycle
//   while the output is not stalled, through the single read port of the history memory
// path: from input request to first output word a word passes the
//   command queue, the history read stage and the output register
// a four-entry command queue decouples the classifier from the copy engine,
//   so input keeps flowing while a copy drains, until the queue fills
// reset: synchronous, clears group position, flag mask, history pointer and
//   all valid flags; history contents are not swept, slots not yet written
//   in the current stream read as zero via the fill pointer, so the block
//   takes input in the cycle after reset and again right after a stream end
// stall: when raw_words is not ready the output register holds, the read
//   stage and then the queue back up, and cmp_words.ready drops when full
module lz_word_history_decompressor_top
  import lzwd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2048
)(
  input  logic       clk,
  input  logic       rst,
  lzwd_in_if.sink    cmp_words,
  lzwd_out_if.source raw_words
);

  // front to queue
  logic push_valid;
  cmd_t push_cmd;
  logic push_ready;

  // queue to back end
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // classifier: group position and flag mask
  lzwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmp_words  (cmp_words),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // short command queue
  lzwd_cmd_fifo u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (cmd_valid),
    .pop_cmd    (cmd),
    .pop        (cmd_pop)
  );

  // copy engine with history memory and output register
  lzwd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .raw_words (raw_words)
  );

endmodule
